### design/dda_pkg.sv
// Package for the DDA line rasterizer: widths, fixed-point constants,
// operation codes and sequencer states. No dependencies.
package dda_pkg;

    // Coordinate and fixed-point widths
    localparam int COORD_BITS = 10;
    localparam int FRAC_BITS  = 16;

    // Derived widths
    localparam int STEPS_W = COORD_BITS + 1;           // step count, |dx|, |dy|
    localparam int REM_W   = STEPS_W + 1;              // divider remainder
    localparam int QUOT_W  = FRAC_BITS + 1;            // increment magnitude, up to 1.0
    localparam int STEP_W  = FRAC_BITS + 2;            // signed increment
    localparam int ACC_W   = COORD_BITS + FRAC_BITS + 2; // signed accumulator
    localparam int CNT_W   = $clog2(FRAC_BITS + 1);    // divider bit counter

    // One half in accumulator format
    localparam logic [ACC_W-1:0] HALF_FIX = ACC_W'(1) << (FRAC_BITS - 1);

    // Input operation codes
    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } op_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_X,
        ST_DIV_Y
    } seq_state_t;

endpackage

### design/dda_if.sv
// Valid/ready channel interfaces for the DDA line rasterizer.
// Depends on dda_pkg for the coordinate width.

// Line command word: operation and endpoints
interface dda_in_if
    import dda_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic                  op;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;

    modport source (output valid, op, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, op, start_x, start_y, end_x, end_y, output ready);
endinterface

// Pixel word: rounded point and flags
interface dda_out_if
    import dda_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;
    logic                  is_last;
    logic                  is_valid;

    modport source (output valid, point_x, point_y, is_last, is_valid, input ready);
    modport sink   (input valid, point_x, point_y, is_last, is_valid, output ready);
endinterface

### design/dda_line_rasterizer.sv
// DDA line rasterizer top level: line setup with a shared restoring divider,
// fixed-point stepping and a registered pixel output. Depends on dda_pkg, dda_if.
//
//  channel    dir  handshake      word
//  line_in    in   valid/ready    op, start_x, start_y, end_x, end_y
//  pixel_out  out  valid/ready    point_x, point_y, is_last, is_valid
//
// A step word (op 1) has its pixel registered the next cycle.
// A start word (op 0) with a nonzero length runs the divider once per axis,
// one quotient bit per cycle, x first and then y, then registers the start pixel.
// A zero-length start word registers its start point as the last pixel without dividing.
// line_in.ready is low while dividing and while an unread pixel is stalled.
// Reset clears the line state; no line is active afterwards.
module dda_line_rasterizer
    import dda_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    dda_in_if.sink    line_in,
    dda_out_if.source pixel_out
);

    // Sequencer and line state
    seq_state_t                state_reg, state_next;
    logic signed [ACC_W-1:0]   acc_x_reg, acc_x_next;   // accumulator plus one half
    logic signed [ACC_W-1:0]   acc_y_reg, acc_y_next;
    logic signed [STEP_W-1:0]  step_x_reg, step_x_next;
    logic signed [STEP_W-1:0]  step_y_reg, step_y_next;
    logic [STEPS_W-1:0]        steps_left_reg, steps_left_next;
    logic                      line_active_reg, line_active_next;

    // Divider state
    logic [REM_W-1:0]          rem_reg, rem_next;
    logic [STEPS_W-1:0]        den_reg, den_next;
    logic [QUOT_W-1:0]         quot_reg, quot_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [STEPS_W-1:0]        mag_y_reg, mag_y_next;
    logic                      neg_x_reg, neg_x_next;
    logic                      neg_y_reg, neg_y_next;

    // Output register
    logic                      out_valid_reg, out_valid_next;
    logic [COORD_BITS-1:0]     out_x_reg, out_x_next;
    logic [COORD_BITS-1:0]     out_y_reg, out_y_next;
    logic                      out_last_reg, out_last_next;
    logic                      out_ok_reg, out_ok_next;

    // Control
    logic                      in_ready;
    logic                      accept;
    logic                      div_last;

    // Setup arithmetic
    logic signed [STEPS_W-1:0] dx, dy;
    logic [STEPS_W-1:0]        adx, ady, steps;

    // Shared divider unit
    logic [REM_W:0]            trial;
    logic                      qbit;
    logic [REM_W-1:0]          rem_sel;
    logic [QUOT_W-1:0]         quot_fin;
    logic [STEP_W-1:0]         quot_ext;
    logic signed [STEP_W-1:0]  step_res;

    // Stepping adders
    logic signed [ACC_W-1:0]   sum_x, sum_y;

    // Endpoint deltas and step count
    always_comb
    begin
        dx    = signed'({1'b0, line_in.end_x}) - signed'({1'b0, line_in.start_x});
        dy    = signed'({1'b0, line_in.end_y}) - signed'({1'b0, line_in.start_y});
        adx   = dx[STEPS_W-1] ? STEPS_W'(-dx) : STEPS_W'(dx);
        ady   = dy[STEPS_W-1] ? STEPS_W'(-dy) : STEPS_W'(dy);
        steps = (adx > ady) ? adx : ady;
    end

    // Divider: one restoring step per cycle
    always_comb
    begin
        trial    = {1'b0, rem_reg} - {2'b00, den_reg};
        qbit     = ~trial[REM_W];
        rem_sel  = qbit ? trial[REM_W-1:0] : rem_reg;
        quot_fin = {quot_reg[QUOT_W-2:0], qbit};
        quot_ext = {1'b0, quot_fin};
        step_res = (state_reg == ST_DIV_X ? neg_x_reg : neg_y_reg)
                   ? signed'(-quot_ext) : signed'(quot_ext);
    end

    // Accumulator advance
    always_comb
    begin
        sum_x = acc_x_reg + {{(ACC_W-STEP_W){step_x_reg[STEP_W-1]}}, step_x_reg};
        sum_y = acc_y_reg + {{(ACC_W-STEP_W){step_y_reg[STEP_W-1]}}, step_y_reg};
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && line_in.op == OP_START && steps != '0)
                    state_next = ST_DIV_X;
            end
            ST_DIV_X:
            begin
                if (div_last)
                    state_next = ST_DIV_Y;
            end
            ST_DIV_Y:
            begin
                if (div_last)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || pixel_out.ready);
        accept   = line_in.valid && in_ready;
        div_last = (cnt_reg == '0);
    end

    // Datapath next values
    always_comb
    begin
        acc_x_next       = acc_x_reg;
        acc_y_next       = acc_y_reg;
        step_x_next      = step_x_reg;
        step_y_next      = step_y_reg;
        steps_left_next  = steps_left_reg;
        line_active_next = line_active_reg;
        rem_next         = rem_reg;
        den_next         = den_reg;
        quot_next        = quot_reg;
        cnt_next         = cnt_reg;
        mag_y_next       = mag_y_reg;
        neg_x_next       = neg_x_reg;
        neg_y_next       = neg_y_reg;
        out_valid_next   = out_valid_reg && !pixel_out.ready;
        out_x_next       = out_x_reg;
        out_y_next       = out_y_reg;
        out_last_next    = out_last_reg;
        out_ok_next      = out_ok_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && line_in.op == OP_START)
                begin
                    // New line: load start point, abandon any active line
                    acc_x_next       = (ACC_W'(line_in.start_x) << FRAC_BITS) | HALF_FIX;
                    acc_y_next       = (ACC_W'(line_in.start_y) << FRAC_BITS) | HALF_FIX;
                    step_x_next      = '0;
                    step_y_next      = '0;
                    steps_left_next  = '0;
                    line_active_next = 1'b0;
                    rem_next         = {1'b0, adx};
                    den_next         = steps;
                    mag_y_next       = ady;
                    neg_x_next       = dx[STEPS_W-1];
                    neg_y_next       = dy[STEPS_W-1];
                    cnt_next         = CNT_W'(FRAC_BITS);
                    if (steps == '0)
                    begin
                        // Zero-length line: start point is also the last
                        out_valid_next = 1'b1;
                        out_x_next     = line_in.start_x;
                        out_y_next     = line_in.start_y;
                        out_last_next  = 1'b1;
                        out_ok_next    = 1'b1;
                    end
                end
                else if (accept)
                begin
                    out_valid_next = 1'b1;
                    if (line_active_reg)
                    begin
                        acc_x_next      = sum_x;
                        acc_y_next      = sum_y;
                        steps_left_next = steps_left_reg - 1'b1;
                        out_x_next      = sum_x[FRAC_BITS +: COORD_BITS];
                        out_y_next      = sum_y[FRAC_BITS +: COORD_BITS];
                        out_ok_next     = 1'b1;
                        if (steps_left_reg == STEPS_W'(1))
                        begin
                            out_last_next    = 1'b1;
                            line_active_next = 1'b0;
                        end
                        else
                        begin
                            out_last_next = 1'b0;
                        end
                    end
                    else
                    begin
                        // Step with no line: invalid pixel
                        out_x_next    = '0;
                        out_y_next    = '0;
                        out_last_next = 1'b0;
                        out_ok_next   = 1'b0;
                    end
                end
            end
            ST_DIV_X, ST_DIV_Y:
            begin
                rem_next  = rem_sel << 1;
                quot_next = quot_fin;
                cnt_next  = cnt_reg - 1'b1;
                if (div_last && state_reg == ST_DIV_X)
                begin
                    step_x_next = step_res;
                    rem_next    = {1'b0, mag_y_reg};
                    cnt_next    = CNT_W'(FRAC_BITS);
                end
                else if (div_last)
                begin
                    // Setup done: start the line and show its first point
                    step_y_next      = step_res;
                    steps_left_next  = den_reg;
                    line_active_next = 1'b1;
                    out_valid_next   = 1'b1;
                    out_x_next       = acc_x_reg[FRAC_BITS +: COORD_BITS];
                    out_y_next       = acc_y_reg[FRAC_BITS +: COORD_BITS];
                    out_last_next    = 1'b0;
                    out_ok_next      = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            acc_x_reg       <= '0;
            acc_y_reg       <= '0;
            step_x_reg      <= '0;
            step_y_reg      <= '0;
            steps_left_reg  <= '0;
            line_active_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            acc_x_reg       <= acc_x_next;
            acc_y_reg       <= acc_y_next;
            step_x_reg      <= step_x_next;
            step_y_reg      <= step_y_next;
            steps_left_reg  <= steps_left_next;
            line_active_reg <= line_active_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        den_reg      <= den_next;
        quot_reg     <= quot_next;
        cnt_reg      <= cnt_next;
        mag_y_reg    <= mag_y_next;
        neg_x_reg    <= neg_x_next;
        neg_y_reg    <= neg_y_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_last_reg <= out_last_next;
        out_ok_reg   <= out_ok_next;
    end

    // Ports
    assign line_in.ready      = in_ready;
    assign pixel_out.valid    = out_valid_reg;
    assign pixel_out.point_x  = out_x_reg;
    assign pixel_out.point_y  = out_y_reg;
    assign pixel_out.is_last  = out_last_reg;
    assign pixel_out.is_valid = out_ok_reg;

    // Checks
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        line_in.ready |-> state_reg == ST_IDLE)
        else $error("ready raised while dividing");

    a_no_out_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !out_valid_reg)
        else $error("pixel pending during line setup");

    a_active_count: assert property (@(posedge clk) disable iff (!rst_n)
        line_active_reg == (steps_left_reg != '0))
        else $error("step count disagrees with active flag");

    a_step_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && line_in.op == OP_STEP) |=> out_valid_reg)
        else $error("step word produced no pixel");

    a_setup_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV_Y && div_last) |=> (out_valid_reg && line_active_reg))
        else $error("line setup did not start the line");

endmodule

### tb/dda_pixel_checker.sv
// Scoreboard for the DDA line rasterizer: predicts the pixel word for each
// accepted command word and compares it with the pixel words the block emits.
// Depends on dda_pkg and the channel interfaces in dda_if.
module dda_pixel_checker
    import dda_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    dda_in_if    line_in,
    dda_out_if   pixel_out,
    output int   errors,
    output int   pending
);

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  last;
        logic                  ok;
    } pixel_t;

    // Predicted line state
    logic signed [ACC_W-1:0]  acc_x;
    logic signed [ACC_W-1:0]  acc_y;
    logic signed [STEP_W-1:0] inc_x;
    logic signed [STEP_W-1:0] inc_y;
    logic [STEPS_W-1:0]       left;
    logic                     line_on;

    pixel_t expected_pixels[$];
    int     pixels_seen;

    task automatic report_fault(string msg);
        errors++;
        $display("[%0t] pixel %0d: %s", $time, pixels_seen, msg);
    endtask

    // (delta << FRAC_BITS) / len, truncated toward zero
    function automatic logic signed [STEP_W-1:0] frac_quot(int delta, int len);
        longint unsigned mag;
        longint unsigned q;
        logic signed [STEP_W-1:0] res;
        mag = (delta < 0) ? longint'(-delta) : longint'(delta);
        q   = (mag << FRAC_BITS) / longint'(len);
        res = STEP_W'(q);
        if (delta < 0)
            res = -res;
        return res;
    endfunction

    // floor(acc + 1/2), kept to the coordinate width
    function automatic logic [COORD_BITS-1:0] round_half_up(logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] biased;
        biased = acc + HALF_FIX;
        return COORD_BITS'(biased >>> FRAC_BITS);
    endfunction

    // Advance the predicted state by one command word and return its pixel
    function automatic pixel_t trace_pixel(logic op, logic [COORD_BITS-1:0] sx,
                                           logic [COORD_BITS-1:0] sy,
                                           logic [COORD_BITS-1:0] ex,
                                           logic [COORD_BITS-1:0] ey);
        pixel_t px;
        int dx;
        int dy;
        int adx;
        int ady;
        int len;
        px = '0;
        if (op == OP_START)
        begin
            dx  = int'(ex) - int'(sx);
            dy  = int'(ey) - int'(sy);
            adx = (dx < 0) ? -dx : dx;
            ady = (dy < 0) ? -dy : dy;
            len = (adx > ady) ? adx : ady;
            acc_x = ACC_W'({sx, {FRAC_BITS{1'b0}}});
            acc_y = ACC_W'({sy, {FRAC_BITS{1'b0}}});
            px.x  = sx;
            px.y  = sy;
            px.ok = 1'b1;
            if (len == 0)
            begin
                // zero-length line: start point is also the last one
                inc_x   = '0;
                inc_y   = '0;
                left    = '0;
                line_on = 1'b0;
                px.last = 1'b1;
            end
            else
            begin
                inc_x   = frac_quot(dx, len);
                inc_y   = frac_quot(dy, len);
                left    = STEPS_W'(len);
                line_on = 1'b1;
            end
        end
        else if (line_on)
        begin
            acc_x   = acc_x + inc_x;
            acc_y   = acc_y + inc_y;
            left    = left - 1'b1;
            px.x    = round_half_up(acc_x);
            px.y    = round_half_up(acc_y);
            px.ok   = 1'b1;
            px.last = (left == '0);
            if (left == '0)
                line_on = 1'b0;
        end
        // step with no active line: all-zero word, state untouched
        return px;
    endfunction

    // Compare pixel words first, then queue the prediction for a new command
    always @(posedge clk or negedge rst_n)
    begin
        pixel_t want;
        if (!rst_n)
        begin
            acc_x   = '0;
            acc_y   = '0;
            inc_x   = '0;
            inc_y   = '0;
            left    = '0;
            line_on = 1'b0;
            expected_pixels.delete();
            pending = 0;
        end
        else
        begin
            if (pixel_out.valid && pixel_out.ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    report_fault("pixel word with no command outstanding");
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (pixel_out.point_x !== want.x)
                        report_fault($sformatf("point_x expected %0d, got %0d",
                                               want.x, pixel_out.point_x));
                    if (pixel_out.point_y !== want.y)
                        report_fault($sformatf("point_y expected %0d, got %0d",
                                               want.y, pixel_out.point_y));
                    if (pixel_out.is_last !== want.last)
                        report_fault($sformatf("is_last expected %0b, got %0b",
                                               want.last, pixel_out.is_last));
                    if (pixel_out.is_valid !== want.ok)
                        report_fault($sformatf("is_valid expected %0b, got %0b",
                                               want.ok, pixel_out.is_valid));
                end
                pixels_seen++;
            end
            if (line_in.valid && line_in.ready)
                expected_pixels.push_back(trace_pixel(line_in.op, line_in.start_x,
                                                      line_in.start_y, line_in.end_x,
                                                      line_in.end_y));
            pending = expected_pixels.size();
        end
    end

endmodule

### tb/testbench.sv
// Top of the DDA line rasterizer bench: clock, reset, command word stimulus,
// pixel sink with back-pressure, watchdog and verdict.
// Depends on dda_pkg, dda_if, the rasterizer RTL and dda_pixel_checker.
module testbench;
    import dda_pkg::*;

    localparam int CMAX           = (1 << COORD_BITS) - 1;
    localparam int PHASE_WORDS    = 240;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 2 * (FRAC_BITS + 1) + 16;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum {
        PH_DIRECTED,
        PH_FREE,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH,
        PH_DRAIN
    } load_phase_t;

    logic        clk;
    logic        rst_n;
    int          errors;
    int          pending;
    int          words_sent;
    load_phase_t phase;

    load_phase_t plan[8] = '{PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH,
                             PH_FREE, PH_BOTH, PH_RECV_STALL, PH_SEND_IDLE};

    dda_in_if  line_in();
    dda_out_if pixel_out();

    dda_line_rasterizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .line_in   (line_in),
        .pixel_out (pixel_out)
    );

    dda_pixel_checker scoreboard (
        .clk       (clk),
        .rst_n     (rst_n),
        .line_in   (line_in),
        .pixel_out (pixel_out),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Offer one command word, with random idle cycles ahead of it
    task automatic send_word(op_t op, int sx, int sy, int ex, int ey);
        int idle_pct;
        idle_pct = (phase == PH_SEND_IDLE) ? 51 : (phase == PH_BOTH) ? 33 : 0;
        while ($urandom_range(99) < idle_pct)
        begin
            line_in.valid <= 1'b0;
            @(negedge clk);
        end
        line_in.valid   <= 1'b1;
        line_in.op      <= op;
        line_in.start_x <= COORD_BITS'(sx);
        line_in.start_y <= COORD_BITS'(sy);
        line_in.end_x   <= COORD_BITS'(ex);
        line_in.end_y   <= COORD_BITS'(ey);
        @(posedge clk);
        while (!line_in.ready)
            @(posedge clk);
        words_sent++;
        @(negedge clk);
    endtask

    // Start a line, then step it a given number of times (endpoint fields are noise)
    task automatic run_line(int sx, int sy, int ex, int ey, int advances);
        send_word(OP_START, sx, sy, ex, ey);
        repeat (advances)
            send_word(OP_STEP, $urandom_range(CMAX), $urandom_range(CMAX),
                      $urandom_range(CMAX), $urandom_range(CMAX));
    endtask

    function automatic int nearby(int base, int span);
        int v;
        v = base + int'($urandom_range(2 * span)) - span;
        if (v < 0)
            v = 0;
        if (v > CMAX)
            v = CMAX;
        return v;
    endfunction

    // One random burst: mostly whole lines, some abandoned, some raw noise
    task automatic random_burst();
        int kind;
        int sx;
        int sy;
        int ex;
        int ey;
        int adx;
        int ady;
        int len;
        int advances;
        kind = $urandom_range(99);
        if (kind < 90)
        begin
            sx = $urandom_range(CMAX);
            sy = $urandom_range(CMAX);
            if (kind < 5)
            begin
                ex = sx;
                ey = sy;
            end
            else if (kind < 80)
            begin
                ex = nearby(sx, (kind < 65) ? 16 : 100);
                ey = nearby(sy, (kind < 65) ? 16 : 100);
            end
            else
            begin
                ex = $urandom_range(CMAX);
                ey = $urandom_range(CMAX);
            end
            adx = (ex > sx) ? ex - sx : sx - ex;
            ady = (ey > sy) ? ey - sy : sy - ey;
            len = (adx > ady) ? adx : ady;
            if (kind >= 80)
                advances = $urandom_range(20);
            else if ($urandom_range(9) == 0)
                advances = $urandom_range(len);
            else
                advances = len + (($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0);
            run_line(sx, sy, ex, ey, advances);
        end
        else
        begin
            repeat ($urandom_range(1, 4))
                send_word(op_t'($urandom_range(1)), $urandom_range(CMAX),
                          $urandom_range(CMAX), $urandom_range(CMAX),
                          $urandom_range(CMAX));
        end
    endtask

    // Pixel sink: random stalls per phase, long hold-off on entering a free phase
    initial
    begin : pixel_sink
        load_phase_t seen;
        int          hold_left;
        int          stall_pct;
        pixel_out.ready <= 1'b0;
        seen      = PH_DIRECTED;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (phase == PH_FREE && seen != PH_FREE)
                hold_left = HOLD_CYCLES;
            seen      = phase;
            stall_pct = (phase == PH_RECV_STALL) ? 51 : (phase == PH_BOTH) ? 33 : 0;
            if (hold_left > 0)
            begin
                pixel_out.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                pixel_out.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Watchdog: too long without any word moving on either channel
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((line_in.valid && line_in.ready) || (pixel_out.valid && pixel_out.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // Command word stimulus and verdict
    initial
    begin : line_source
        int target;
        line_in.valid   <= 1'b0;
        line_in.op      <= OP_START;
        line_in.start_x <= '0;
        line_in.start_y <= '0;
        line_in.end_x   <= '0;
        line_in.end_y   <= '0;
        phase           <= PH_DIRECTED;
        words_sent      = 0;
        rst_n           <= 1'b0;
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // step with no line after reset
        send_word(OP_STEP, CMAX, CMAX, CMAX, CMAX);
        // zero-length lines at both corners, the first followed by a stray step
        run_line(0, 0, 0, 0, 1);
        run_line(CMAX, CMAX, CMAX, CMAX, 0);
        // shallow line run past its end
        run_line(0, 0, 3, 1, 4);
        // negative x with thirds in y
        run_line(CMAX, 0, CMAX - 3, 2, 3);
        // full diagonal, abandoned by a new line
        run_line(0, CMAX, CMAX, 0, 2);
        // vertical line
        run_line(5, 5, 5, 7, 2);
        // increment of exactly one half: rounds up at the midpoint
        run_line(0, 0, 4, 2, 4);

        target = words_sent;
        foreach (plan[i])
        begin
            phase <= plan[i];
            target += PHASE_WORDS;
            do
                random_burst();
            while (words_sent < target);
        end

        line_in.valid <= 1'b0;
        phase         <= PH_DRAIN;
        wait (pending == 0);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
